// ----- hw/rtl/rcws_pkg.sv -----
// Shared types and constants of the raycaster wall column setup block.
`default_nettype none

package rcws_pkg;

    localparam int SCREEN_HEIGHT_DEF = 1024;
    localparam int FRAC_W            = 16;
    localparam int IN_W              = 32;
    localparam int DIST_W            = 31;
    localparam int HEIGHT_W          = 22;
    localparam int ROW_W             = 12;
    localparam int TEX_W             = 16;

    localparam logic [DIST_W-1:0]   DIST_MIN   = DIST_W'(66);
    localparam logic [DIST_W-1:0]   DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};

    typedef struct packed {
        logic                   hit_side;
        logic signed [IN_W-1:0] next_x_edge_dist;
        logic signed [IN_W-1:0] next_y_edge_dist;
        logic signed [IN_W-1:0] step_x_dist;
        logic signed [IN_W-1:0] step_y_dist;
        logic signed [IN_W-1:0] dir_x;
        logic signed [IN_W-1:0] dir_y;
        logic signed [IN_W-1:0] viewer_x;
        logic signed [IN_W-1:0] viewer_y;
    } t_col_in;

    typedef struct packed {
        logic [DIST_W-1:0]   wall_distance;
        logic [HEIGHT_W-1:0] column_height;
        logic [ROW_W-1:0]    first_row;
        logic [ROW_W-1:0]    last_row;
        logic [TEX_W-1:0]    texture_fraction;
    } t_col_out;

endpackage

`default_nettype wire

// ----- hw/rtl/rcws_if.sv -----
// Valid/ready channel interfaces for column input and result items.
`default_nettype none

interface rcws_in_if;
    import rcws_pkg::*;

    logic    valid;
    logic    ready;
    t_col_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rcws_out_if;
    import rcws_pkg::*;

    logic     valid;
    logic     ready;
    t_col_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rcws_div.sv -----
// Pipelined restoring divider: constant numerator over a per-item divisor.
`default_nettype none

module rcws_div #(
    parameter int                 NUM_W = 27,
    parameter int                 DEN_W = 31,
    parameter int                 TAG_W = 16,
    parameter logic [NUM_W-1:0]   NUMER = '0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [NUM_W-1:0]      o_quo,
    output logic [DEN_W-1:0]      o_den,
    output logic [TAG_W-1:0]      o_tag
);

    // one quotient bit per stage, MSB first
    logic             r_vld [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [TAG_W-1:0] r_tag [NUM_W];

    logic             n_vld [NUM_W];
    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] n_quo [NUM_W];
    logic [DEN_W-1:0] n_den [NUM_W];
    logic [TAG_W-1:0] n_tag [NUM_W];

    always_comb begin
        logic [DEN_W-1:0] w_rem_in;
        logic [NUM_W-1:0] w_quo_in;
        logic [DEN_W:0]   w_trial;
        for (int s = 0; s < NUM_W; s++) begin
            if (s == 0) begin
                n_vld[s] = i_valid;
                n_den[s] = i_den;
                n_tag[s] = i_tag;
                w_rem_in = '0;
                w_quo_in = '0;
            end else begin
                n_vld[s] = r_vld[s-1];
                n_den[s] = r_den[s-1];
                n_tag[s] = r_tag[s-1];
                w_rem_in = r_rem[s-1];
                w_quo_in = r_quo[s-1];
            end

            w_trial = {w_rem_in, NUMER[NUM_W-1-s]};

            if (w_trial >= {1'b0, n_den[s]}) begin
                n_rem[s] = DEN_W'(w_trial - {1'b0, n_den[s]});
                n_quo[s] = {w_quo_in[NUM_W-2:0], 1'b1};
            end else begin
                n_rem[s] = w_trial[DEN_W-1:0];
                n_quo[s] = {w_quo_in[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_W; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            for (int s = 0; s < NUM_W; s++) begin
                r_vld[s] <= n_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NUM_W; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_den[s] <= n_den[s];
                r_tag[s] <= n_tag[s];
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_quo[NUM_W-1];
    assign o_den   = r_den[NUM_W-1];
    assign o_tag   = r_tag[NUM_W-1];

endmodule

`default_nettype wire

// ----- hw/rtl/rcws_skid.sv -----
// Output skid stage that decouples the pipeline from the result channel.
`default_nettype none

module rcws_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire rcws_pkg::t_col_out i_data,
    output logic                   o_en,
    rcws_out_if.source             o_col
);
    import rcws_pkg::*;

    logic     r_skid_vld;
    t_col_out r_skid;

    // pipeline moves whenever the skid slot is free
    assign o_en = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (!r_skid_vld) begin
            r_skid_vld <= i_valid && !o_col.ready;
        end else if (o_col.ready) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid <= i_data;
        end
    end

    assign o_col.valid = r_skid_vld || i_valid;
    assign o_col.data  = r_skid_vld ? r_skid : i_data;

endmodule

`default_nettype wire

// ----- hw/rtl/raycast_wall_column_setup.sv -----
// Top level: per-column wall distance, slice height, row span and texture fraction.
// Items pass stage 1, stage 2, the bit-per-stage height divider and the output register;
//   one column per cycle sustained while no result item is stalled in the skid slot.
// Input ready drops only while the output skid slot holds a stalled item.
// Reset (synchronous, active low) clears all valid bits and the skid slot;
//   the block holds no other state.
`default_nettype none

module raycast_wall_column_setup #(
    parameter int SCREEN_HEIGHT = rcws_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rcws_in_if.sink     i_col,
    rcws_out_if.source  o_col
);
    import rcws_pkg::*;

    // Numerator of the height division is SCREEN_HEIGHT with 16 fraction bits (Q11.16 at 1024 rows).
    localparam int NUM_W = $clog2(SCREEN_HEIGHT + 1) + FRAC_W;
    localparam int Q_W   = (NUM_W > HEIGHT_W) ? NUM_W : HEIGHT_W;
    localparam logic [NUM_W-1:0] NUMER = NUM_W'(SCREEN_HEIGHT) << FRAC_W;
    localparam logic [ROW_W-1:0] HALF_SCREEN = ROW_W'(SCREEN_HEIGHT / 2);
    localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(SCREEN_HEIGHT - 1);

    logic w_en;

    // ---------------------------------------------------------------
    // Stage 1: pick the hit axis, subtract step from side distance and
    // clamp into [DIST_MIN, DIST_MAX]. Keep only what later stages need.
    // ---------------------------------------------------------------
    logic signed [IN_W:0] w_dist_raw;
    logic [DIST_W-1:0]    w_dist;

    always_comb begin
        if (i_col.data.hit_side) begin
            w_dist_raw = (IN_W+1)'(i_col.data.next_y_edge_dist)
                       - (IN_W+1)'(i_col.data.step_y_dist);
        end else begin
            w_dist_raw = (IN_W+1)'(i_col.data.next_x_edge_dist)
                       - (IN_W+1)'(i_col.data.step_x_dist);
        end
        if (w_dist_raw < $signed({2'b00, DIST_MIN})) begin
            w_dist = DIST_MIN;
        end else if (w_dist_raw > $signed({2'b00, DIST_MAX})) begin
            w_dist = DIST_MAX;
        end else begin
            w_dist = w_dist_raw[DIST_W-1:0];
        end
    end

    logic              r_s1_vld;
    logic [DIST_W-1:0] r_s1_dist;
    logic [IN_W-1:0]   r_s1_dir;
    logic [TEX_W-1:0]  r_s1_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_col.valid;
        end
    end

    // The hit coordinate runs along the other axis: y for an x-facing wall.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_dist <= w_dist;
            if (i_col.data.hit_side) begin
                r_s1_dir <= i_col.data.dir_x;
                r_s1_pos <= i_col.data.viewer_x[TEX_W-1:0];
            end else begin
                r_s1_dir <= i_col.data.dir_y;
                r_s1_pos <= i_col.data.viewer_y[TEX_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: dir * distance. Only product bits [31:16] reach the
    // fraction, so a truncated 32-bit product is enough.
    // ---------------------------------------------------------------
    logic [IN_W-1:0]   w_prod;
    logic              r_s2_vld;
    logic [DIST_W-1:0] r_s2_dist;
    logic [TEX_W-1:0]  r_s2_prod;
    logic [TEX_W-1:0]  r_s2_pos;

    assign w_prod = IN_W'(r_s1_dir * IN_W'(r_s1_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_dist <= r_s1_dist;
            r_s2_prod <= w_prod[IN_W-1:FRAC_W];
            r_s2_pos  <= r_s1_pos;
        end
    end

    // ---------------------------------------------------------------
    // Divider stages: height = NUMER / distance. The texture fraction
    // (wrapping 16-bit add of position and product) rides as the tag.
    // ---------------------------------------------------------------
    logic [TEX_W-1:0]  w_tex;
    logic              w_div_vld;
    logic [NUM_W-1:0]  w_div_quo;
    logic [DIST_W-1:0] w_div_dist;
    logic [TEX_W-1:0]  w_div_tex;

    assign w_tex = TEX_W'(r_s2_pos + r_s2_prod);

    rcws_div #(
        .NUM_W (NUM_W),
        .DEN_W (DIST_W),
        .TAG_W (TEX_W),
        .NUMER (NUMER)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_vld),
        .i_den   (r_s2_dist),
        .i_tag   (w_tex),
        .o_valid (w_div_vld),
        .o_quo   (w_div_quo),
        .o_den   (w_div_dist),
        .o_tag   (w_div_tex)
    );

    // ---------------------------------------------------------------
    // Final stage: saturate the height and place the slice on screen.
    // ---------------------------------------------------------------
    logic [Q_W-1:0]      w_quo_ext;
    logic [HEIGHT_W-1:0] w_height;
    logic [HEIGHT_W-2:0] w_half_h;
    logic [HEIGHT_W-1:0] w_last_sum;
    logic [ROW_W-1:0]    w_first;
    logic [ROW_W-1:0]    w_last;

    always_comb begin
        w_quo_ext = Q_W'(w_div_quo);
        if (w_quo_ext > Q_W'(HEIGHT_MAX)) begin
            w_height = HEIGHT_MAX;
        end else begin
            w_height = w_quo_ext[HEIGHT_W-1:0];
        end
        w_half_h = w_height[HEIGHT_W-1:1];

        // first row: half screen minus half height, floored at zero
        if (w_half_h >= (HEIGHT_W-1)'(HALF_SCREEN)) begin
            w_first = '0;
        end else begin
            w_first = HALF_SCREEN - w_half_h[ROW_W-1:0];
        end

        // last row: half height plus half screen, capped at the bottom row
        w_last_sum = HEIGHT_W'(w_half_h) + HEIGHT_W'(HALF_SCREEN);
        if (w_last_sum >= HEIGHT_W'(SCREEN_HEIGHT)) begin
            w_last = LAST_ROW;
        end else begin
            w_last = w_last_sum[ROW_W-1:0];
        end
    end

    logic     r_out_vld;
    t_col_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.wall_distance    <= w_div_dist;
            r_out.column_height    <= w_height;
            r_out.first_row        <= w_first;
            r_out.last_row         <= w_last;
            r_out.texture_fraction <= w_div_tex;
        end
    end

    // ---------------------------------------------------------------
    // Output skid slot: catch the last stage's item when the sink stalls,
    // then hold the whole pipeline until it drains.
    // ---------------------------------------------------------------
    rcws_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_out_vld),
        .i_data  (r_out),
        .o_en    (w_en),
        .o_col   (o_col)
    );

    assign i_col.ready = w_en;

endmodule

`default_nettype wire

// ----- hw/rtl/rcws_chk.sv -----
// Port-level checker for the wall column setup block, with its bind.
`default_nettype none

module rcws_chk #(
    parameter int SCREEN_HEIGHT = rcws_pkg::SCREEN_HEIGHT_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [rcws_pkg::DIST_W-1:0]   i_wall_distance,
    input wire logic [rcws_pkg::ROW_W-1:0]    i_first_row,
    input wire logic [rcws_pkg::ROW_W-1:0]    i_last_row
);
    import rcws_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // input is refused only right after a stalled result
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_out_valid && !i_out_ready) |-> i_in_ready)
        else $error("input stalled without a result stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item right after reset");

    // distance floor and a slice that lies on screen in row order
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_wall_distance >= DIST_MIN && i_first_row <= i_last_row
                        && i_last_row <= LAST_ROW)
        else $error("result item out of range");

endmodule

bind raycast_wall_column_setup rcws_chk #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_rcws_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_col.ready),
    .i_out_valid     (o_col.valid),
    .i_out_ready     (o_col.ready),
    .i_wall_distance (o_col.data.wall_distance),
    .i_first_row     (o_col.data.first_row),
    .i_last_row      (o_col.data.last_row)
);

`default_nettype wire
